/* src/cslex_pkg.sv */
// Shared types, constants and character functions for the C subset lexer.
`default_nettype none

package cslex_pkg;

  localparam int STORE_DEPTH = 32;
  localparam logic [15:0] CAP_RESET = 16'd1024;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_SEMI = ";";

  localparam logic [23:0] KW_INT_TXT = "int";
  localparam logic [47:0] KW_RETURN_TXT = "return";
  localparam logic [31:0] KW_VOID_TXT = "void";

  localparam logic [1:0] KW_SEL_INT = 2'd0;
  localparam logic [1:0] KW_SEL_RETURN = 2'd1;
  localparam logic [1:0] KW_SEL_VOID = 2'd2;

  typedef enum logic [3:0] {
    TK_INT     = 4'd0,
    TK_RETURN  = 4'd1,
    TK_VOID    = 4'd2,
    TK_IDENT   = 4'd3,
    TK_CONST   = 4'd4,
    TK_LPAREN  = 4'd5,
    TK_RPAREN  = 4'd6,
    TK_LBRACE  = 4'd7,
    TK_RBRACE  = 4'd8,
    TK_SEMI    = 4'd9,
    TK_END     = 4'd10,
    TK_INVALID = 4'd11
  } tok_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_IDENT     = 2'd1,
    MODE_CONST     = 2'd2,
    MODE_DIRECTIVE = 2'd3
  } scan_mode_t;

  typedef enum logic [2:0] {
    CL_SPACE,
    CL_HASH,
    CL_ALPHA,
    CL_DIGIT,
    CL_PUNCT,
    CL_OTHER
  } byte_class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_KW,
    ST_TAIL
  } fsm_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] token_number;
    logic [5:0]  text_length;
    logic [4:0]  text_index;
    logic [7:0]  text_byte;
    logic        was_truncated;
    logic        was_dropped;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    logic       wr_en;
    logic [4:0] wr_addr;
    logic [7:0] wr_data;
    logic [4:0] rd_addr;
  } mem_req_t;

  function automatic byte_class_t byte_class(input logic [7:0] b);
    byte_class_t c;
    c = CL_OTHER;
    if (b == CH_HASH) begin
      c = CL_HASH;
    end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
      c = CL_SPACE;
    end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER) begin
      c = CL_ALPHA;
    end else if (b >= "0" && b <= "9") begin
      c = CL_DIGIT;
    end else if (b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE ||
                 b == CH_RBRACE || b == CH_SEMI) begin
      c = CL_PUNCT;
    end
    return c;
  endfunction

  function automatic tok_kind_t punct_kind(input logic [7:0] b);
    tok_kind_t k;
    k = TK_SEMI;
    if (b == CH_LPAREN) begin
      k = TK_LPAREN;
    end else if (b == CH_RPAREN) begin
      k = TK_RPAREN;
    end else if (b == CH_LBRACE) begin
      k = TK_LBRACE;
    end else if (b == CH_RBRACE) begin
      k = TK_RBRACE;
    end
    return k;
  endfunction

  function automatic logic [5:0] kw_len(input logic [1:0] sel);
    logic [5:0] n;
    n = 6'd0;
    if (sel == KW_SEL_INT) begin
      n = 6'd3;
    end else if (sel == KW_SEL_RETURN) begin
      n = 6'd6;
    end else if (sel == KW_SEL_VOID) begin
      n = 6'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (sel == KW_SEL_INT && idx < 3'd3) begin
      c = KW_INT_TXT[8*(2-int'(idx)) +: 8];
    end else if (sel == KW_SEL_RETURN && idx < 3'd6) begin
      c = KW_RETURN_TXT[8*(5-int'(idx)) +: 8];
    end else if (sel == KW_SEL_VOID && idx < 3'd4) begin
      c = KW_VOID_TXT[8*(3-int'(idx)) +: 8];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/cslex_word_mem.sv */
// Word buffer memory: one write port and one registered read port.
`default_nettype none

module cslex_word_mem (
  input  logic              clk,
  input  cslex_pkg::mem_req_t mem_req,
  output logic [7:0]        rd_data
);
  import cslex_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    rd_data_r <= mem[mem_req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/cslex_scan.sv */
// Scanner control: classifies bytes, fills the word buffer and sequences token results.
`default_nettype none

module cslex_scan #(
  parameter int WORD_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cslex_pkg::in_item_t  in_data,
  input  logic [15:0]          token_cap,
  input  logic                 out_space,
  output logic                 emit,
  output cslex_pkg::out_item_t emit_item,
  output cslex_pkg::mem_req_t  mem_req,
  input  logic [7:0]           rd_data
);
  import cslex_pkg::*;

  localparam int WordKeep = (WORD_MAX < STORE_DEPTH) ? WORD_MAX : STORE_DEPTH;
  localparam logic [5:0] KeepLen = 6'(WordKeep);

  fsm_state_t  state_r, state_nxt;
  scan_mode_t  mode_r, mode_nxt;
  logic [5:0]  len_r, len_nxt;
  logic        cut_r, cut_nxt;
  logic [15:0] total_r, total_nxt;
  logic [2:0]  kw_r, kw_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        end_r, end_nxt;
  logic [4:0]  k_r, k_nxt;

  logic [7:0]  cur_byte;
  logic        cur_end;
  byte_class_t cls;
  logic        drop;
  logic        in_word;
  logic        word_cont;
  logic        tail_out;
  logic        kw_hit;
  tok_kind_t   kw_kind;
  logic        do_tail;
  logic        do_append;
  logic        app_start;
  logic [5:0]  pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= MODE_IDLE;
      len_r   <= 6'd0;
      cut_r   <= 1'b0;
      total_r <= 16'd0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      cut_r   <= cut_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kw_r   <= kw_nxt;
    byte_r <= byte_nxt;
    end_r  <= end_nxt;
    k_r    <= k_nxt;
  end

  always_comb begin
    cur_byte  = (state_r == ST_IDLE) ? in_data.in_byte : byte_r;
    cur_end   = (state_r == ST_IDLE) ? in_data.is_end : end_r;
    cls       = byte_class(cur_byte);
    drop      = (total_r >= token_cap);
    in_word   = (mode_r == MODE_IDENT) || (mode_r == MODE_CONST);
    word_cont = ((mode_r == MODE_IDENT) && (cls == CL_ALPHA || cls == CL_DIGIT)) ||
                ((mode_r == MODE_CONST) && (cls == CL_DIGIT));
    tail_out  = cur_end || (cls == CL_PUNCT) || (cls == CL_OTHER);
    kw_hit    = (mode_r == MODE_IDENT) && !cut_r &&
                ((kw_r[0] && len_r == kw_len(KW_SEL_INT)) ||
                 (kw_r[1] && len_r == kw_len(KW_SEL_RETURN)) ||
                 (kw_r[2] && len_r == kw_len(KW_SEL_VOID)));
    if (kw_r[0] && len_r == kw_len(KW_SEL_INT)) begin
      kw_kind = TK_INT;
    end else if (kw_r[1] && len_r == kw_len(KW_SEL_RETURN)) begin
      kw_kind = TK_RETURN;
    end else begin
      kw_kind = TK_VOID;
    end

    state_nxt = state_r;
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    cut_nxt   = cut_r;
    total_nxt = total_r;
    kw_nxt    = kw_r;
    byte_nxt  = byte_r;
    end_nxt   = end_r;
    k_nxt     = k_r;
    emit      = 1'b0;
    emit_item = '0;
    mem_req   = '0;
    mem_req.rd_addr = k_r;
    in_stall  = (state_r != ST_IDLE);
    do_tail   = 1'b0;
    do_append = 1'b0;
    app_start = 1'b0;
    pos       = len_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data.in_byte;
          end_nxt  = in_data.is_end;
          k_nxt    = 5'd0;
          if (cur_end) begin
            if (in_word) begin
              state_nxt = kw_hit ? ST_KW : ST_RD;
            end else begin
              state_nxt = ST_TAIL;
            end
          end else if (mode_r == MODE_DIRECTIVE) begin
            if (cur_byte == CH_NL) begin
              mode_nxt = MODE_IDLE;
            end
          end else if (word_cont) begin
            do_append = 1'b1;
          end else if (in_word) begin
            state_nxt = kw_hit ? ST_KW : ST_RD;
          end else if (tail_out) begin
            state_nxt = ST_TAIL;
          end else begin
            do_tail = 1'b1;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (out_space) begin
          emit = 1'b1;
          emit_item.token_kind    = (mode_r == MODE_IDENT) ? TK_IDENT : TK_CONST;
          emit_item.token_number  = total_r;
          emit_item.text_length   = len_r;
          emit_item.text_index    = k_r;
          emit_item.text_byte     = rd_data;
          emit_item.was_truncated = cut_r;
          emit_item.was_dropped   = drop;
          if ({1'b0, k_r} == len_r - 6'd1) begin
            emit_item.last_result = !tail_out;
            if (!drop) begin
              total_nxt = total_r + 16'd1;
            end
            state_nxt = ST_TAIL;
          end else begin
            k_nxt     = k_r + 5'd1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_KW: begin
        if (out_space) begin
          emit = 1'b1;
          emit_item.token_kind   = kw_kind;
          emit_item.token_number = total_r;
          emit_item.was_dropped  = drop;
          emit_item.last_result  = !tail_out;
          if (!drop) begin
            total_nxt = total_r + 16'd1;
          end
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (!tail_out || out_space) begin
          do_tail   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_tail) begin
      mode_nxt = MODE_IDLE;
      len_nxt  = 6'd0;
      cut_nxt  = 1'b0;
      if (cur_end) begin
        emit = 1'b1;
        emit_item.token_kind   = TK_END;
        emit_item.token_number = total_r;
        emit_item.was_dropped  = drop;
        emit_item.last_result  = 1'b1;
        total_nxt = 16'd0;
      end else begin
        unique case (cls)
          CL_HASH: begin
            mode_nxt = MODE_DIRECTIVE;
          end
          CL_SPACE: begin
            mode_nxt = MODE_IDLE;
          end
          CL_ALPHA: begin
            mode_nxt  = MODE_IDENT;
            app_start = 1'b1;
          end
          CL_DIGIT: begin
            mode_nxt  = MODE_CONST;
            app_start = 1'b1;
          end
          CL_PUNCT: begin
            emit = 1'b1;
            emit_item.token_kind   = punct_kind(cur_byte);
            emit_item.token_number = total_r;
            emit_item.was_dropped  = drop;
            emit_item.last_result  = 1'b1;
            if (!drop) begin
              total_nxt = total_r + 16'd1;
            end
          end
          CL_OTHER: begin
            emit = 1'b1;
            emit_item.token_kind   = TK_INVALID;
            emit_item.token_number = total_r;
            emit_item.last_result  = 1'b1;
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end

    if (do_append || app_start) begin
      pos = app_start ? 6'd0 : len_r;
      if (pos < KeepLen) begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = pos[4:0];
        mem_req.wr_data = cur_byte;
        len_nxt         = pos + 6'd1;
        for (int j = 0; j < 3; j++) begin
          kw_nxt[j] = (app_start || kw_r[j]) && (pos < kw_len(2'(j))) &&
                      (cur_byte == kw_char(2'(j), pos[2:0]));
        end
      end else begin
        cut_nxt = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/c_subset_lexer_core.sv */
// Top level of the C subset lexer: configuration register, output register and scanner.
// A byte with no result is taken while idle; punctuation, invalid bytes and the end
// marker pass through ST_TAIL, a byte ending a keyword through ST_KW then ST_TAIL, and
// one ending a word through ST_RD and ST_WR per stored byte, then ST_TAIL. A result
// held by out_stall holds back the next result. Synchronous active-low reset clears the
// scanner FSM and sets token_cap to 1024; the word buffer is not cleared.
`default_nettype none

module c_subset_lexer_core #(
  parameter int WORD_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cslex_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cslex_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data
);
  import cslex_pkg::*;

  logic [15:0] cap_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;
  logic        out_space;
  logic        emit;
  out_item_t   emit_item;
  mem_req_t    mem_req;
  logic [7:0]  rd_data;

  assign out_space     = !out_valid_r || !out_stall;
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  cslex_scan #(
    .WORD_MAX (WORD_MAX)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .token_cap (cap_r),
    .out_space (out_space),
    .emit      (emit),
    .emit_item (emit_item),
    .mem_req   (mem_req),
    .rd_data   (rd_data)
  );

  cslex_word_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

/* src/cslex_chk.sv */
// Port-level checker for the C subset lexer and its bind to the top level.
`default_nettype none

module cslex_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input cslex_pkg::out_item_t out_data
);
  import cslex_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == TK_END |-> out_data.last_result)
    else $error("end token is not the final result of its transfer");

  a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind == TK_INVALID |->
      !out_data.was_dropped && out_data.text_length == 6'd0)
    else $error("invalid-character result carries a drop flag or text");

  a_text_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == TK_IDENT || out_data.token_kind == TK_CONST) |->
      {1'b0, out_data.text_index} < out_data.text_length)
    else $error("text index outside the word length");

endmodule

bind c_subset_lexer_core cslex_chk u_chk (.*);

`default_nettype wire
